>>> sv/xee_pkg.sv
package xee_pkg;

    // Input beat: one raw byte of the string.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_end;
    } in_item_t;

    // Output beat: one byte of the escaped text.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_done;
        logic       any_escaped;
    } out_item_t;

    // Class of an input byte as decided by the front end.
    typedef enum logic [2:0] {
        KIND_PASS,
        KIND_LT,
        KIND_GT,
        KIND_AMP,
        KIND_APOS,
        KIND_QUOT
    } kind_t;

    // One queued, classified byte.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] raw;
        logic       last;
        logic       any;
    } entry_t;

    // Queue status seen by both ends.
    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

    // Characters that need escaping.
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_APOS = 8'h27;
    localparam logic [7:0] CH_QUOT = 8'h22;

    // Entity texts, left aligned in six byte slots.
    localparam logic [47:0] ENT_LT   = {"&lt;", 16'h0000};
    localparam logic [47:0] ENT_GT   = {"&gt;", 16'h0000};
    localparam logic [47:0] ENT_AMP  = {"&amp;", 8'h00};
    localparam logic [47:0] ENT_APOS = "&apos;";
    localparam logic [47:0] ENT_QUOT = "&quot;";

    // Number of output bytes produced for one class.
    function automatic logic [2:0] ent_len(input kind_t kind);
        logic [2:0] len;
        begin
            case (kind)
                KIND_LT:   len = 3'd4;
                KIND_GT:   len = 3'd4;
                KIND_AMP:  len = 3'd5;
                KIND_APOS: len = 3'd6;
                KIND_QUOT: len = 3'd6;
                default:   len = 3'd1;
            endcase
            return len;
        end
    endfunction

    // Byte at position idx of the run for a class; raw byte for pass-through.
    function automatic logic [7:0] ent_byte(input kind_t kind, input logic [7:0] raw,
                                            input logic [2:0] idx);
        logic [47:0] text;
        logic [7:0]  res;
        begin
            case (kind)
                KIND_LT:   text = ENT_LT;
                KIND_GT:   text = ENT_GT;
                KIND_AMP:  text = ENT_AMP;
                KIND_APOS: text = ENT_APOS;
                KIND_QUOT: text = ENT_QUOT;
                default:   text = '0;
            endcase
            if (kind == KIND_PASS)
            begin
                res = raw;
            end
            else
            begin
                res = text[(6'd47 - {idx, 3'b000}) -: 8];
            end
            return res;
        end
    endfunction

endpackage

>>> sv/xee_front.sv
module xee_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_attribute_mode,
    input  logic              in_valid,
    output logic              in_ready,
    input  xee_pkg::in_item_t in_item,
    input  xee_pkg::q_status_t q_status,
    output logic              push,
    output xee_pkg::entry_t   push_entry
);
    import xee_pkg::*;

    logic  attribute_mode_reg;
    logic  escaped_seen_reg;
    logic  escaped_seen_next;
    kind_t kind;
    logic  is_esc;

    // The mode register can be written at any time.
    assign cfg_ready = 1'b1;

    // Classify the incoming byte against the current mode.
    always_comb
    begin
        case (in_item.in_byte)
            CH_LT:   kind = KIND_LT;
            CH_GT:   kind = KIND_GT;
            CH_AMP:  kind = KIND_AMP;
            CH_APOS: kind = attribute_mode_reg ? KIND_APOS : KIND_PASS;
            CH_QUOT: kind = attribute_mode_reg ? KIND_QUOT : KIND_PASS;
            default: kind = KIND_PASS;
        endcase
    end

    assign is_esc   = (kind != KIND_PASS);
    assign in_ready = !q_status.full;
    assign push     = in_valid && in_ready;

    // Build the queue entry, carrying the running flag including this byte.
    always_comb
    begin
        push_entry.kind = kind;
        push_entry.raw  = in_item.in_byte;
        push_entry.last = in_item.string_end;
        push_entry.any  = escaped_seen_reg | is_esc;
    end

    // The running flag clears once a string's final byte is taken.
    always_comb
    begin
        escaped_seen_next = escaped_seen_reg;
        if (push)
        begin
            escaped_seen_next = in_item.string_end ? 1'b0 : (escaped_seen_reg | is_esc);
        end
    end

    // Mode and flag registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attribute_mode_reg <= 1'b0;
            escaped_seen_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                attribute_mode_reg <= cfg_attribute_mode;
            end
            escaped_seen_reg <= escaped_seen_next;
        end
    end

endmodule

>>> sv/xee_queue.sv
module xee_queue #(
    parameter int DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  xee_pkg::entry_t    push_entry,
    input  logic               pop,
    output xee_pkg::entry_t    head_entry,
    output xee_pkg::q_status_t q_status
);
    import xee_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_next;

    assign q_status.full      = (count_reg == CNT_W'(DEPTH));
    assign q_status.not_empty = (count_reg != '0);
    assign head_entry         = slot_reg[rd_ptr_reg];

    // Pointer wrap and occupancy.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // A full queue is never written and an empty one never read.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !push)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !q_status.not_empty |-> !pop)
        else $error("queue read while empty");

endmodule

>>> sv/xee_back.sv
module xee_back (
    input  logic               clk,
    input  logic               rst_n,
    input  xee_pkg::entry_t    head_entry,
    input  xee_pkg::q_status_t q_status,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output xee_pkg::out_item_t out_item
);
    import xee_pkg::*;

    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic       out_valid_reg;
    out_item_t  out_item_reg;
    out_item_t  out_item_next;
    logic [2:0] len;
    logic       tail;
    logic       advance;

    assign len     = ent_len(head_entry.kind);
    assign tail    = (idx_reg == (len - 3'd1));
    assign advance = q_status.not_empty && (!out_valid_reg || out_ready);
    assign pop     = advance && tail;

    // Next byte of the current run.
    always_comb
    begin
        out_item_next.out_byte    = ent_byte(head_entry.kind, head_entry.raw, idx_reg);
        out_item_next.run_last    = tail;
        out_item_next.string_done = tail && head_entry.last;
        out_item_next.any_escaped = head_entry.any;
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (advance)
        begin
            idx_next = tail ? 3'd0 : idx_reg + 3'd1;
        end
    end

    // Run position and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // The run position stays inside the entity and rests at zero between runs.
    a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.not_empty |-> (idx_reg < len))
        else $error("run position beyond entity length");

    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !q_status.not_empty |-> (idx_reg == 3'd0))
        else $error("run position left mid-entity with empty queue");

    a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.string_done) |-> out_item_reg.run_last)
        else $error("string end marked before the last byte of a run");

    a_pop_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (idx_reg == 3'd0) && out_valid_reg && out_item_reg.run_last)
        else $error("entry released without its final byte");

endmodule

>>> sv/xml_entity_escaper_top.sv
// Channel   Beat           Handshake              Direction
// in        in_item_t      in_valid / in_ready    into block
// out       out_item_t     out_valid / out_ready  out of block
// cfg       mode bit       cfg_valid / cfg_ready  into block
//
// One output beat per cycle unless out_ready is low; a plain byte gives one beat, an
// escaped byte four to six. Input is taken every cycle while the classified-byte queue
// has room; it fills as entities drain through the single expansion counter or output
// stalls. A byte passes a queue slot, then the output register, before its first beat.
// Reset is asynchronous and clears the mode, the running flag, the queue and out_valid.
// Either side may stall at any time; the queue and the output register absorb it.
module xml_entity_escaper_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_attribute_mode,
    input  logic               in_valid,
    output logic               in_ready,
    input  xee_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output xee_pkg::out_item_t out_item
);
    import xee_pkg::*;

    q_status_t q_status;
    entry_t    push_entry;
    entry_t    head_entry;
    logic      push;
    logic      pop;

    // Front end: mode register, classification and running flag.
    xee_front u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_attribute_mode (cfg_attribute_mode),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .in_item            (in_item),
        .q_status           (q_status),
        .push               (push),
        .push_entry         (push_entry)
    );

    // Queue of classified bytes between the two ends.
    xee_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .q_status   (q_status)
    );

    // Back end: entity expansion into output beats.
    xee_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_entry (head_entry),
        .q_status   (q_status),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

endmodule

>>> bench/tb_xml_entity_escaper_top.sv
`timescale 1ns / 100ps

module tb_xml_entity_escaper_top;

    import xee_pkg::*;

    // Values of the attribute mode register.
    localparam logic MODE_TEXT = 1'b0;
    localparam logic MODE_ATTR = 1'b1;

    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_BYTES    = 75;
    localparam int LONG_HOLD      = 80;
    localparam int TAIL_CYCLES    = 16;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int REPORT_CAP     = 60;

    // One row of the directed table: an optional mode write ahead of the byte, and
    // a beat typed in by hand where the result is obvious.
    typedef struct packed {
        logic      write_mode;
        logic      mode;
        in_item_t  item;
        logic      typed;
        out_item_t beat;
    } escape_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_attribute_mode = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_item;

    // Hand-typed expectation travelling alongside the input beat.
    logic      row_typed = 1'b0;
    out_item_t row_beat = '0;

    // Mirror of the block: mode register and running escape flag.
    logic      mode_mirror = MODE_TEXT;
    logic      string_escaped = 1'b0;
    out_item_t run_beats[$];
    out_item_t escaped_due[$];

    int        mismatches = 0;
    int        quiet_cycles = 0;
    logic      hold_out_req = 1'b0;
    logic      sender_gaps = 1'b1;
    logic      calm_run = 1'b0;

    escape_row_t directed_rows[$];

    xml_entity_escaper_top uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_attribute_mode (cfg_attribute_mode),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .in_item            (in_item),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .out_item           (out_item)
    );

    // Free-running clock, 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Works out the run of output beats for one input byte and updates the flag.
    function automatic void escape_byte(input in_item_t item);
        string     entity;
        int        run_len;
        int        k;
        out_item_t beat;
        entity = "";
        case (item.in_byte)
            CH_LT:   entity = "&lt;";
            CH_GT:   entity = "&gt;";
            CH_AMP:  entity = "&amp;";
            CH_APOS: if (mode_mirror == MODE_ATTR) entity = "&apos;";
            CH_QUOT: if (mode_mirror == MODE_ATTR) entity = "&quot;";
            default: ;
        endcase
        run_len = (entity.len() == 0) ? 1 : entity.len();
        if (entity.len() != 0)
        begin
            string_escaped = 1'b1;
        end
        run_beats.delete();
        for (k = 0; k < run_len; k++)
        begin
            beat.out_byte    = (entity.len() == 0) ? item.in_byte : entity[k];
            beat.run_last    = (k == run_len - 1);
            beat.string_done = beat.run_last && item.string_end;
            beat.any_escaped = string_escaped;
            run_beats.push_back(beat);
        end
        // The flag starts afresh with the next string.
        if (item.string_end)
        begin
            string_escaped = 1'b0;
        end
    endfunction

    function automatic void compare_field(input string field, input int unsigned want,
                                          input int unsigned got);
        if (want != got)
        begin
            if (mismatches < REPORT_CAP)
            begin
                $display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
            end
            mismatches++;
        end
    endfunction

    // Follows every handshake: mode writes, accepted bytes and delivered beats.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                mode_mirror = cfg_attribute_mode;
            end
            if (in_valid && in_ready)
            begin
                escape_byte(in_item);
                if (row_typed)
                begin
                    escaped_due.push_back(row_beat);
                end
                else
                begin
                    foreach (run_beats[i])
                    begin
                        escaped_due.push_back(run_beats[i]);
                    end
                end
            end
            if (out_valid && out_ready)
            begin
                if (escaped_due.size() == 0)
                begin
                    if (mismatches < REPORT_CAP)
                    begin
                        $display("%0t ns: expected no beat, got %h", $time, out_item);
                    end
                    mismatches++;
                end
                else
                begin
                    want = escaped_due.pop_front();
                    compare_field("out_byte", want.out_byte, out_item.out_byte);
                    compare_field("run_last", want.run_last, out_item.run_last);
                    compare_field("string_done", want.string_done, out_item.string_done);
                    compare_field("any_escaped", want.any_escaped, out_item.any_escaped);
                end
            end
        end
    end

    // Ends the run if nothing at all is accepted for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Receiver: bursts of back-pressure, runs of free flow, and one long hold on request.
    initial
    begin
        int span;
        forever
        begin
            @(posedge clk);
            if (hold_out_req)
            begin
                out_ready <= 1'b0;
                for (span = 0; span < LONG_HOLD; span++)
                begin
                    @(posedge clk);
                end
                hold_out_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if (!calm_run && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    function automatic escape_row_t row_of(input logic wr, input logic mode,
                                           input logic [7:0] raw, input logic last,
                                           input logic typed, input logic [7:0] ob,
                                           input logic rl, input logic sd, input logic ae);
        escape_row_t row;
        row.write_mode       = wr;
        row.mode             = mode;
        row.item.in_byte     = raw;
        row.item.string_end  = last;
        row.typed            = typed;
        row.beat.out_byte    = ob;
        row.beat.run_last    = rl;
        row.beat.string_done = sd;
        row.beat.any_escaped = ae;
        return row;
    endfunction

    // Four draws in ten are characters that matter to the escaper, the rest printable or arbitrary.
    function automatic in_item_t random_byte();
        in_item_t item;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                case ($urandom_range(0, 4))
                    0:       item.in_byte = CH_LT;
                    1:       item.in_byte = CH_GT;
                    2:       item.in_byte = CH_AMP;
                    3:       item.in_byte = CH_APOS;
                    default: item.in_byte = CH_QUOT;
                endcase
            end
            4, 5, 6, 7: item.in_byte = 8'($urandom_range(8'h20, 8'h7E));
            default:    item.in_byte = 8'($urandom_range(0, 255));
        endcase
        item.string_end = ($urandom_range(0, 5) == 0);
        return item;
    endfunction

    // Offers one beat and holds it until taken, then perhaps leaves a gap.
    task automatic offer_byte(input in_item_t item, input logic typed, input out_item_t beat);
        in_item   <= item;
        row_typed <= typed;
        row_beat  <= beat;
        in_valid  <= 1'b1;
        do @(posedge clk); while (!in_ready);
        if (sender_gaps && !calm_run && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    // Stops sending and waits for every outstanding beat to arrive.
    task automatic drain_beats();
        in_valid <= 1'b0;
        do @(posedge clk); while (escaped_due.size() != 0);
    endtask

    // The mode register is only written once the block has gone idle.
    task automatic write_mode(input logic mode);
        drain_beats();
        cfg_attribute_mode <= mode;
        cfg_valid          <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Stimulus: reset, the directed table, random phases, then the final drain.
    initial
    begin
        int phase;
        int n;
        directed_rows = '{
            row_of(1'b1, MODE_TEXT, 8'h00, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1, 1'b0),
            row_of(1'b0, MODE_TEXT, 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b0),
            row_of(1'b0, MODE_TEXT, CH_QUOT, 1'b1, 1'b1, CH_QUOT, 1'b1, 1'b1, 1'b0),
            row_of(1'b0, MODE_TEXT, CH_APOS, 1'b1, 1'b1, CH_APOS, 1'b1, 1'b1, 1'b0),
            row_of(1'b0, MODE_TEXT, 8'h41, 1'b0, 1'b1, 8'h41, 1'b1, 1'b0, 1'b0),
            row_of(1'b0, MODE_TEXT, CH_LT, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0),
            row_of(1'b0, MODE_TEXT, 8'h42, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0),
            row_of(1'b0, MODE_TEXT, CH_GT, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0),
            row_of(1'b0, MODE_TEXT, CH_AMP, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0),
            row_of(1'b0, MODE_TEXT, 8'h43, 1'b1, 1'b1, 8'h43, 1'b1, 1'b1, 1'b0),
            row_of(1'b1, MODE_ATTR, CH_APOS, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0),
            row_of(1'b0, MODE_ATTR, CH_QUOT, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0),
            row_of(1'b0, MODE_ATTR, CH_LT, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0),
            row_of(1'b0, MODE_ATTR, 8'h7F, 1'b0, 1'b1, 8'h7F, 1'b1, 1'b0, 1'b0),
            row_of(1'b0, MODE_ATTR, 8'h80, 1'b0, 1'b1, 8'h80, 1'b1, 1'b0, 1'b0),
            // Mode falls back to plain text in the middle of a string.
            row_of(1'b1, MODE_TEXT, CH_QUOT, 1'b0, 1'b1, CH_QUOT, 1'b1, 1'b0, 1'b0),
            row_of(1'b0, MODE_TEXT, CH_AMP, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0),
            row_of(1'b1, MODE_ATTR, 8'hAA, 1'b0, 1'b1, 8'hAA, 1'b1, 1'b0, 1'b0),
            row_of(1'b0, MODE_ATTR, 8'h55, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0),
            row_of(1'b0, MODE_ATTR, CH_GT, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0),
            row_of(1'b0, MODE_ATTR, 8'h01, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0),
            row_of(1'b0, MODE_ATTR, 8'hFE, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0)
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].write_mode)
            begin
                write_mode(directed_rows[i].mode);
            end
            offer_byte(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].beat);
        end

        // Random phases, each under its own mode; the last runs without any gaps.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_mode(($urandom_range(0, 1) == 1) ? MODE_ATTR : MODE_TEXT);
            sender_gaps = (phase != 2);
            calm_run    = (phase == RANDOM_PHASES - 1);
            for (n = 0; n < PHASE_BYTES; n++)
            begin
                // The receiver stops for a long while as the sender keeps pushing.
                if (phase == 1 && n == 20)
                begin
                    hold_out_req = 1'b1;
                end
                // The sender waits for the block to empty before going on.
                if (phase == 3 && n == 40)
                begin
                    drain_beats();
                end
                offer_byte(random_byte(), 1'b0, '0);
            end
        end

        drain_beats();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && escaped_due.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> xml_entity_escaper_top.f
sv/xee_pkg.sv
sv/xee_front.sv
sv/xee_queue.sv
sv/xee_back.sv
sv/xml_entity_escaper_top.sv
bench/tb_xml_entity_escaper_top.sv
